FILE: src/bpl_pkg.sv
`default_nettype none

package bpl_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_REMOVE_AT  = 3'd5,
    FN_CLEAR      = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/bounded_positional_list_unit.sv
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+-------------------------
// command   | func_i, value_i, position_i                  | start_i & !busy_o
// result    | status_o, removed_value_o, count_o           | valid_o, one cycle
//
// A command is latched on the transfer edge, executed by the shifting entry row
// in the next cycle (busy_o high), and the result shows on the following cycle
// with valid_o while a new command can already transfer. No new command can
// transfer while the execute state holds busy_o high.
// Asynchronous active-low reset empties the list; entry storage is not cleared.
// The receiver cannot stall; each result is strobed exactly once.
`default_nettype none

module bounded_positional_list_unit
  import bpl_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  output logic                      busy_o,
  input  wire  [FUNC_W-1:0]         func_i,
  input  wire  signed [DATA_W-1:0]  value_i,
  input  wire  [POS_W-1:0]          position_i,
  output logic                      valid_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [DATA_W-1:0]  removed_value_o,
  output logic [COUNT_W-1:0]        count_o
);

  cmd_t cmd;

  bpl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  bpl_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o)
  );

endmodule

`default_nettype wire

FILE: src/bpl_ctrl.sv
`default_nettype none

module bpl_ctrl
  import bpl_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  output logic busy_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.exec;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    busy_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign valid_o = valid_q;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EXEC))
    else $error("accepted transfer did not enter execute");

  a_exec_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> valid_o)
    else $error("execute without result strobe");

  a_valid_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while busy");
`endif

endmodule

`default_nettype wire

FILE: src/bpl_datapath.sv
`default_nettype none

module bpl_datapath
  import bpl_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  cmd_t                 cmd_i,
  input  wire  [FUNC_W-1:0]          func_i,
  input  wire  signed [DATA_W-1:0]   value_i,
  input  wire  [POS_W-1:0]           position_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [DATA_W-1:0]   removed_value_o,
  output logic [COUNT_W-1:0]         count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [FUNC_W-1:0]         func_q;
  logic signed [DATA_W-1:0]  val_q;
  logic [POS_W-1:0]          pos_q;

  logic [CW-1:0]             cnt_q, cnt_d;
  logic signed [VALUE_BITS-1:0] cells_q [CAPACITY];
  logic signed [VALUE_BITS-1:0] cells_d [CAPACITY];

  status_e                   status_q, st;
  logic signed [DATA_W-1:0]  removed_q, got;

  logic [PW-1:0]             cnt_w, pos_w, ins_pos, rem_pos;
  logic                      ins_req, rem_req, full, empty;
  logic signed [VALUE_BITS-1:0] v_in;

  assign cnt_w = PW'(cnt_q);
  assign pos_w = PW'(pos_q);
  assign full  = (cnt_w == PW'(CAPACITY));
  assign empty = (cnt_q == '0);
  assign v_in  = VALUE_BITS'(val_q);

  always_comb begin
    cells_d = cells_q;
    cnt_d   = cnt_q;
    st      = ST_OK;
    got     = '0;
    ins_req = 1'b0;
    rem_req = 1'b0;
    ins_pos = '0;
    rem_pos = '0;
    case (func_e'(func_q))
      FN_PUSH_FRONT: begin
        ins_req = 1'b1;
      end
      FN_PUSH_BACK: begin
        ins_req = 1'b1;
        ins_pos = cnt_w;
      end
      FN_INSERT_AT: begin
        ins_req = 1'b1;
        ins_pos = pos_w;
      end
      FN_POP_FRONT: begin
        rem_req = 1'b1;
      end
      FN_POP_BACK: begin
        rem_req = 1'b1;
        rem_pos = cnt_w - 1'b1;
      end
      FN_REMOVE_AT: begin
        rem_req = 1'b1;
        rem_pos = pos_w;
      end
      FN_CLEAR: begin
        st    = empty ? ST_EMPTY : ST_OK;
        cnt_d = '0;
      end
      default: begin
      end
    endcase

    if (ins_req) begin
      if (full) begin
        st = ST_FULL;
      end else if (ins_pos > cnt_w) begin
        st = ST_BADPOS;
      end else begin
        for (int i = 1; i < CAPACITY; i++) begin
          if (PW'(i) > ins_pos) begin
            cells_d[i] = cells_q[i-1];
          end
        end
        cells_d[ins_pos[IW-1:0]] = v_in;
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (rem_req) begin
      if (empty) begin
        st = ST_EMPTY;
      end else if (rem_pos >= cnt_w) begin
        st = ST_BADPOS;
      end else begin
        got = DATA_W'(cells_q[rem_pos[IW-1:0]]);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (PW'(i) >= rem_pos) begin
            cells_d[i] = cells_q[i+1];
          end
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      val_q  <= value_i;
      pos_q  <= position_i;
    end
    if (cmd_i.exec) begin
      cells_q   <= cells_d;
      status_q  <= st;
      removed_q <= got;
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = COUNT_W'(cnt_q);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("count above capacity");

  a_fail_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (status_q == ST_OK) || $stable(cnt_q))
    else $error("failed operation changed count");

  a_fail_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (status_q == ST_OK) || (removed_q == '0))
    else $error("failed operation returned a value");
`endif

endmodule

`default_nettype wire
